/* src/dlml_pkg.sv */
`timescale 1ns / 1ps
package dlml_pkg;

    localparam int MAX_MATCH  = 256;
    localparam int MAX_GROUPS = 16;
    localparam int MAX_SUB    = 16;

    // input item kinds
    localparam logic [2:0] K_DATA    = 3'd0;
    localparam logic [2:0] K_EOI     = 3'd1;
    localparam logic [2:0] K_RESET   = 3'd2;
    localparam logic [2:0] K_LD_TRAN = 3'd3;
    localparam logic [2:0] K_LD_INFO = 3'd4;
    localparam logic [2:0] K_SET_OFS = 3'd5;

    // result status codes
    localparam logic [1:0] ST_CONT  = 2'd0;
    localparam logic [1:0] ST_MATCH = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;
    localparam logic [1:0] ST_GROUP = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_LIMIT = 2'd0;
    localparam logic [1:0] CFG_INCR  = 2'd1;
    localparam logic [1:0] CFG_GCNT  = 2'd2;

    typedef struct packed {
        logic        accept;
        logic        final_f;
        logic [15:0] open_m;
        logic [15:0] close_m;
        logic [3:0]  first;
        logic [4:0]  count;
    } t_info;

    // command word to the group unit
    typedef struct packed {
        logic       clear;
        logic       apply;
        logic       trim;
        logic [15:0] open_m;
        logic [15:0] close_m;
        logic [8:0] pos;
    } t_grp_cmd;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  accept_state;
        logic [31:0] match_offset;
        logic [8:0]  match_length;
        logic [3:0]  group_index;
        logic        group_present;
        logic [7:0]  group_offset;
        logic [8:0]  group_length;
        logic [31:0] resume_offset;
        logic        last;
    } t_rec;

endpackage

/* src/dlml_if.sv */
`timescale 1ns / 1ps
interface dlml_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic        chunk_end;
    logic [7:0]  state_index;
    logic signed [8:0] next_state;
    logic        accept_flag;
    logic        final_flag;
    logic [15:0] open_mask;
    logic [15:0] close_mask;
    logic [3:0]  first_group;
    logic [4:0]  accept_groups;
    logic [31:0] offset_value;
    modport source (output valid, kind, data_byte, chunk_end, state_index, next_state,
                    accept_flag, final_flag, open_mask, close_mask, first_group,
                    accept_groups, offset_value, input ready);
    modport sink (input valid, kind, data_byte, chunk_end, state_index, next_state,
                  accept_flag, final_flag, open_mask, close_mask, first_group,
                  accept_groups, offset_value, output ready);
endinterface

interface dlml_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  accept_state;
    logic [31:0] match_offset;
    logic [8:0]  match_length;
    logic [3:0]  group_index;
    logic        group_present;
    logic [7:0]  group_offset;
    logic [8:0]  group_length;
    logic [31:0] resume_offset;
    logic        last;
    modport source (output valid, status, accept_state, match_offset, match_length,
                    group_index, group_present, group_offset, group_length,
                    resume_offset, last, input ready);
    modport sink (input valid, status, accept_state, match_offset, match_length,
                  group_index, group_present, group_offset, group_length,
                  resume_offset, last, output ready);
endinterface

interface dlml_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [8:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* src/dlml_groups.sv */
`timescale 1ns / 1ps
module dlml_groups (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dlml_pkg::t_grp_cmd i_cmd,
    input  logic [4:0]         i_active,
    input  logic [4:0]         i_rd_idx,
    output logic               o_present,
    output logic [7:0]         o_offset,
    output logic [8:0]         o_length
);
    import dlml_pkg::*;

    logic [MAX_GROUPS-1:0] r_valid;
    logic [8:0]            r_start [MAX_GROUPS];
    logic [8:0]            r_end   [MAX_GROUPS];

    // update every group slot in parallel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            for (int g = 0; g < MAX_GROUPS; g++) begin
                if (i_cmd.clear) begin
                    r_valid[g] <= 1'b0;
                    r_start[g] <= '0;
                    r_end[g]   <= '0;
                end else if (5'(g) < i_active) begin
                    if (i_cmd.apply) begin
                        if (i_cmd.open_m[g]) begin
                            r_valid[g] <= 1'b1;
                            r_start[g] <= i_cmd.pos;
                        end
                        if (i_cmd.open_m[g] || i_cmd.close_m[g])
                            r_end[g] <= i_cmd.pos;
                    end else if (i_cmd.trim && r_valid[g]) begin
                        if (r_start[g] >= i_cmd.pos)
                            r_valid[g] <= 1'b0;
                        else if (r_end[g] > i_cmd.pos)
                            r_end[g] <= i_cmd.pos;
                    end
                end
            end
        end
    end

    // report one group
    logic [3:0] w_idx;
    assign w_idx     = i_rd_idx[3:0];
    assign o_present = (i_rd_idx < i_active) && r_valid[w_idx] && (r_end[w_idx] > r_start[w_idx]);
    assign o_offset  = o_present ? r_start[w_idx][7:0] : 8'd0;
    assign o_length  = o_present ? (r_end[w_idx] - r_start[w_idx]) : 9'd0;

endmodule

/* src/dfa_longest_match_lexer_top.sv */
`timescale 1ns / 1ps
// DFA longest-match lexer.
// Channels: i_in takes one word per item (data byte, end of input, reset, table
// loads, set offset); o_out gives result words (continue, match, error, and one
// sub-group word per group that a match reports); i_cfg writes the length limit,
// incremental mode and group count, and is always ready.
// A data byte that continues: S_TCHK checks the transition table read, S_SAPP
// completes the state info read and group update, S_CEMIT emits the continue
// word, and S_IDLE takes the next item. A match word goes through S_MRD, S_MAPP
// and S_MEMIT instead (from S_TCHK on rollback, from S_SAPP on a final state),
// then one sub-group word per cycle while the receiver is ready, then soft reset
// (S_SRST, S_SRAP), also run by a reset item. The block takes one item at a
// time: the transition and state info memories each have one read port, and
// all group updates run through the single group unit under the sequencer.
// Reset clears the lexer state and marks all groups absent; table memories
// hold whatever they held until loaded. A stalled receiver holds the output
// register, and the sequencer waits for it before emitting the next word.
module dfa_longest_match_lexer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dlml_in_if.sink     i_in,
    dlml_out_if.source  o_out,
    dlml_cfg_if.sink    i_cfg
);
    import dlml_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_TCHK  = 12'b000000000010,
        S_SAPP  = 12'b000000000100,
        S_EOI   = 12'b000000001000,
        S_MRD   = 12'b000000010000,
        S_MAPP  = 12'b000000100000,
        S_MEMIT = 12'b000001000000,
        S_SEMIT = 12'b000010000000,
        S_EEMIT = 12'b000100000000,
        S_CEMIT = 12'b001000000000,
        S_SRST  = 12'b010000000000,
        S_SRAP  = 12'b100000000000
    } t_state;

    t_state      r_state;
    logic [8:0]  r_limit_cfg;
    logic        r_incr;
    logic [4:0]  r_gcnt_cfg;
    logic [7:0]  r_cur;
    logic        r_la_valid;
    logic [7:0]  r_la_state;
    logic [8:0]  r_la_len;
    logic [8:0]  r_bl;
    logic [31:0] r_ms;
    logic [31:0] r_so;
    logic        r_chunk;
    logic [7:0]  r_mstate;
    logic [3:0]  r_first;
    logic [4:0]  r_cnt;
    logic [3:0]  r_sub;
    logic        r_ov;
    t_rec        r_rec;

    // memories
    logic [8:0]  r_tmem [65536];
    logic [8:0]  r_trd;
    t_info       r_imem [256];
    t_info       r_info;
    logic [7:0]  w_info_ra;

    logic [8:0]  w_limit;
    logic [4:0]  w_active;
    logic [8:0]  w_nb;
    logic        w_accept;
    logic        w_free;
    t_grp_cmd    w_gcmd;
    logic [4:0]  w_gidx;
    logic        w_gp;
    logic [7:0]  w_go;
    logic [8:0]  w_gl;

    assign w_limit  = (r_limit_cfg > 9'(MAX_MATCH)) ? 9'(MAX_MATCH) : r_limit_cfg;
    assign w_active = (r_gcnt_cfg > 5'(MAX_GROUPS)) ? 5'(MAX_GROUPS) : r_gcnt_cfg;
    assign w_nb     = r_bl + 9'd1;
    assign w_accept = i_in.valid && i_in.ready;
    assign w_free   = !r_ov || o_out.ready;
    assign w_gidx   = {1'b0, r_first} + {1'b0, r_sub};

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    // transition table: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (w_accept && i_in.kind == K_LD_TRAN)
            r_tmem[{i_in.state_index, i_in.data_byte}] <= i_in.next_state;
        r_trd <= r_tmem[{r_cur, i_in.data_byte}];
    end

    // state info table
    always_comb begin
        case (r_state)
            S_TCHK:  w_info_ra = r_trd[7:0];
            S_SRST:  w_info_ra = 8'd0;
            default: w_info_ra = r_mstate;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_in.kind == K_LD_INFO)
            r_imem[i_in.state_index] <= '{accept: i_in.accept_flag, final_f: i_in.final_flag,
                open_m: i_in.open_mask, close_m: i_in.close_mask,
                first: i_in.first_group, count: i_in.accept_groups};
        r_info <= r_imem[w_info_ra];
    end

    // group unit commands
    always_comb begin
        w_gcmd = '0;
        w_gcmd.open_m  = r_info.open_m;
        w_gcmd.close_m = r_info.close_m;
        w_gcmd.pos     = r_bl;
        case (r_state)
            S_SAPP, S_MAPP, S_SRAP: w_gcmd.apply = 1'b1;
            S_SRST: w_gcmd.clear = 1'b1;
            S_TCHK: begin
                w_gcmd.trim = r_trd[8] && r_la_valid;
                w_gcmd.pos  = r_la_len;
            end
            S_EOI: begin
                w_gcmd.trim = (r_bl != 9'd0) && r_la_valid && (r_la_len < r_bl);
                w_gcmd.pos  = r_la_len;
            end
            default: ;
        endcase
    end

    dlml_groups u_groups (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_gcmd),
        .i_active  (w_active),
        .i_rd_idx  (w_gidx),
        .o_present (w_gp),
        .o_offset  (w_go),
        .o_length  (w_gl)
    );

    // output word register
    assign o_out.valid         = r_ov;
    assign o_out.status        = r_rec.status;
    assign o_out.accept_state  = r_rec.accept_state;
    assign o_out.match_offset  = r_rec.match_offset;
    assign o_out.match_length  = r_rec.match_length;
    assign o_out.group_index   = r_rec.group_index;
    assign o_out.group_present = r_rec.group_present;
    assign o_out.group_offset  = r_rec.group_offset;
    assign o_out.group_length  = r_rec.group_length;
    assign o_out.resume_offset = r_rec.resume_offset;
    assign o_out.last          = r_rec.last;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_limit_cfg <= 9'd256;
            r_incr      <= 1'b0;
            r_gcnt_cfg  <= '0;
            r_cur       <= '0;
            r_la_valid  <= 1'b0;
            r_la_state  <= '0;
            r_la_len    <= '0;
            r_bl        <= '0;
            r_ms        <= '0;
            r_so        <= '0;
            r_ov        <= 1'b0;
            r_sub       <= '0;
        end else begin
            if (r_ov && o_out.ready)
                r_ov <= 1'b0;

            // configuration writes
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_LIMIT: r_limit_cfg <= i_cfg.data;
                    CFG_INCR:  r_incr      <= i_cfg.data[0];
                    CFG_GCNT:  r_gcnt_cfg  <= i_cfg.data[4:0];
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        case (i_in.kind)
                            K_DATA: begin
                                r_so    <= r_so + 32'd1;
                                r_bl    <= w_nb;
                                r_chunk <= i_in.chunk_end;
                                if (w_nb >= w_limit) begin
                                    r_so    <= r_ms;
                                    r_state <= S_EEMIT;
                                end else begin
                                    r_state <= S_TCHK;
                                end
                            end
                            K_EOI:   r_state <= S_EOI;
                            K_RESET: begin
                                r_so    <= '0;
                                r_state <= S_SRST;
                            end
                            K_SET_OFS: begin
                                r_ms <= r_ms + (i_in.offset_value - r_so);
                                r_so <= i_in.offset_value;
                            end
                            default: ;
                        endcase
                    end
                end
                S_TCHK: begin
                    if (r_trd[8]) begin
                        if (r_la_valid) begin
                            r_so     <= r_ms + 32'(r_la_len);
                            r_bl     <= r_la_len;
                            r_mstate <= r_la_state;
                            r_state  <= S_MRD;
                        end else begin
                            r_so    <= r_ms;
                            r_state <= S_EEMIT;
                        end
                    end else begin
                        r_cur   <= r_trd[7:0];
                        r_state <= S_SAPP;
                    end
                end
                S_SAPP: begin
                    if (r_info.accept && r_info.final_f) begin
                        r_mstate <= r_cur;
                        r_state  <= S_MRD;
                    end else begin
                        if (r_info.accept) begin
                            r_la_valid <= 1'b1;
                            r_la_state <= r_cur;
                            r_la_len   <= r_bl;
                        end
                        r_state <= (r_chunk && !r_incr) ? S_EOI : S_CEMIT;
                    end
                end
                S_EOI: begin
                    if (r_bl == 9'd0) begin
                        r_state <= S_CEMIT;
                    end else if (!r_la_valid) begin
                        r_so    <= r_ms;
                        r_state <= S_EEMIT;
                    end else begin
                        if (r_la_len < r_bl) begin
                            r_so <= r_ms + 32'(r_la_len);
                            r_bl <= r_la_len;
                        end
                        r_mstate <= r_la_state;
                        r_state  <= S_MRD;
                    end
                end
                S_MRD:  r_state <= S_MAPP;
                S_MAPP: begin
                    r_first <= r_info.first;
                    r_cnt   <= (r_info.count > 5'(MAX_SUB)) ? 5'(MAX_SUB) : r_info.count;
                    r_state <= S_MEMIT;
                end
                S_MEMIT: begin
                    if (w_free) begin
                        r_ov  <= 1'b1;
                        r_rec <= '{status: ST_MATCH, accept_state: r_mstate, match_offset: r_ms,
                            match_length: r_bl, group_index: 4'd0, group_present: 1'b0,
                            group_offset: 8'd0, group_length: 9'd0, resume_offset: r_so,
                            last: (r_cnt == 5'd0)};
                        r_sub   <= '0;
                        r_state <= (r_cnt == 5'd0) ? S_SRST : S_SEMIT;
                    end
                end
                S_SEMIT: begin
                    if (w_free) begin
                        r_ov  <= 1'b1;
                        r_rec <= '{status: ST_GROUP, accept_state: r_mstate, match_offset: r_ms,
                            match_length: r_bl, group_index: r_sub, group_present: w_gp,
                            group_offset: w_go, group_length: w_gl, resume_offset: r_so,
                            last: ({1'b0, r_sub} == r_cnt - 5'd1)};
                        r_sub <= r_sub + 4'd1;
                        if ({1'b0, r_sub} == r_cnt - 5'd1)
                            r_state <= S_SRST;
                    end
                end
                S_EEMIT: begin
                    if (w_free) begin
                        r_ov  <= 1'b1;
                        r_rec <= '{status: ST_ERROR, accept_state: 8'd0, match_offset: r_ms,
                            match_length: r_bl, group_index: 4'd0, group_present: 1'b0,
                            group_offset: 8'd0, group_length: 9'd0, resume_offset: r_so,
                            last: 1'b1};
                        r_state <= S_SRST;
                    end
                end
                S_CEMIT: begin
                    if (w_free) begin
                        r_ov  <= 1'b1;
                        r_rec <= '{status: ST_CONT, accept_state: 8'd0, match_offset: r_ms,
                            match_length: r_bl, group_index: 4'd0, group_present: 1'b0,
                            group_offset: 8'd0, group_length: 9'd0, resume_offset: r_so,
                            last: 1'b1};
                        r_state <= S_IDLE;
                    end
                end
                S_SRST: begin
                    r_cur      <= '0;
                    r_la_valid <= 1'b0;
                    r_la_len   <= '0;
                    r_ms       <= r_so;
                    r_bl       <= '0;
                    r_state    <= S_SRAP;
                end
                S_SRAP:  r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // checks
    a_bl_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bl <= 9'(MAX_MATCH))
        else $error("buffered length beyond buffer");

    a_la_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_la_valid |-> r_la_len <= r_bl)
        else $error("last accept beyond buffered length");

    a_sub_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEMIT && w_free && {1'b0, r_sub} == r_cnt - 5'd1) |=> r_state == S_SRST)
        else $error("sub-group sequence did not end in soft reset");

    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CEMIT && w_free) |=> (r_ov && r_rec.last))
        else $error("continue word not emitted");

endmodule

/* test/dfa_longest_match_lexer_top_test.sv */
`timescale 1ns / 1ps
module dfa_longest_match_lexer_top_test;
    import dlml_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int N_USED = 5;
    localparam int N_SYM = 12;

    typedef struct {
        logic [2:0]        kind;
        logic [7:0]        data_byte;
        logic              chunk_end;
        logic [7:0]        state_index;
        logic signed [8:0] next_state;
        logic              accept_flag;
        logic              final_flag;
        logic [15:0]       open_mask;
        logic [15:0]       close_mask;
        logic [3:0]        first_group;
        logic [4:0]        accept_groups;
        logic [31:0]       offset_value;
    } lex_word_t;

    logic clk;
    logic rst_n;
    dlml_in_if  in_if ();
    dlml_out_if out_if ();
    dlml_cfg_if cfg_if ();

    dfa_longest_match_lexer_top uut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_if),
        .o_out  (out_if),
        .i_cfg  (cfg_if)
    );

    // states the automaton may ever reach; every one has its symbol columns loaded
    logic [7:0] used_states [N_USED] = '{8'h00, 8'h55, 8'hAA, 8'hFF, 8'h01};
    // the only bytes ever fed as data
    logic [7:0] syms [N_SYM] = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h01, 8'h10,
                                 8'h20, 8'h41, 8'h7E, 8'h80, 8'hC3, 8'hE7};

    // lexer shadow: tables, registers and walk state
    logic [8:0]  trans_m [0:65535];
    logic        inf_acc [256];
    logic        inf_fin [256];
    logic [15:0] inf_open [256];
    logic [15:0] inf_close [256];
    logic [3:0]  inf_first [256];
    logic [4:0]  inf_cnt [256];
    int unsigned grp_s [16];
    int unsigned grp_e [16];
    bit          grp_v [16];
    int unsigned cur_st, acc_len, buf_len;
    int          acc_st;
    logic [31:0] lex_start, stream_pos;
    int unsigned lim_reg, incr_reg, gcnt_reg;

    t_rec lex_words_q [$];
    int   errors;
    int   src_idle_pct, snk_idle_pct, hold_cycles, quiet_cycles;

    // clock and watchdog
    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int unsigned active_groups();
        return (gcnt_reg > 16) ? 16 : gcnt_reg;
    endfunction

    function automatic void enter_groups(int unsigned s);
        int unsigned n;
        n = active_groups();
        for (int g = 0; g < n; g++) begin
            if (inf_open[s][g]) begin
                grp_s[g] = buf_len;
                grp_e[g] = buf_len;
                grp_v[g] = 1'b1;
            end
        end
        for (int g = 0; g < n; g++)
            if (inf_close[s][g]) grp_e[g] = buf_len;
    endfunction

    function automatic void restart_lexeme();
        cur_st = 0;
        acc_st = -1;
        acc_len = 0;
        lex_start = stream_pos;
        buf_len = 0;
        for (int g = 0; g < 16; g++) begin
            grp_v[g] = 1'b0;
            grp_s[g] = 0;
            grp_e[g] = 0;
        end
        enter_groups(0);
    endfunction

    function automatic void push_word(logic [1:0] st, int unsigned acc, logic [31:0] moff,
                                      int unsigned mlen, int unsigned gi, int unsigned gp,
                                      int unsigned go, int unsigned gl);
        t_rec r;
        r.status        = st;
        r.accept_state  = acc[7:0];
        r.match_offset  = moff;
        r.match_length  = mlen[8:0];
        r.group_index   = gi[3:0];
        r.group_present = gp[0];
        r.group_offset  = go[7:0];
        r.group_length  = gl[8:0];
        r.resume_offset = stream_pos;
        r.last          = 1'b0;
        lex_words_q.push_back(r);
    endfunction

    function automatic void emit_match(int unsigned s);
        logic [31:0] moff;
        int unsigned mlen, cnt, n, g;
        int unsigned gp [16], go [16], gl [16];
        moff = lex_start;
        mlen = buf_len;
        cnt = (inf_cnt[s] > 16) ? 16 : inf_cnt[s];
        n = active_groups();
        enter_groups(s);
        for (int i = 0; i < cnt; i++) begin
            g = inf_first[s] + i;
            gp[i] = 0; go[i] = 0; gl[i] = 0;
            if (g < n && grp_v[g] && grp_e[g] > grp_s[g]) begin
                gp[i] = 1;
                go[i] = grp_s[g];
                gl[i] = grp_e[g] - grp_s[g];
            end
        end
        restart_lexeme();
        push_word(ST_MATCH, s, moff, mlen, 0, 0, 0, 0);
        for (int i = 0; i < cnt; i++)
            push_word(ST_GROUP, s, moff, mlen, i, gp[i], go[i], gl[i]);
    endfunction

    function automatic void emit_error();
        logic [31:0] moff;
        int unsigned mlen;
        moff = lex_start;
        mlen = buf_len;
        stream_pos = lex_start;
        restart_lexeme();
        push_word(ST_ERROR, 0, moff, mlen, 0, 0, 0, 0);
    endfunction

    // back up to the last accept and trim groups past it
    function automatic void roll_back();
        int unsigned n;
        n = active_groups();
        stream_pos = lex_start + acc_len;
        buf_len = acc_len;
        for (int g = 0; g < n; g++) begin
            if (grp_v[g]) begin
                if (grp_s[g] >= buf_len) grp_v[g] = 1'b0;
                else if (grp_e[g] > buf_len) grp_e[g] = buf_len;
            end
        end
        emit_match(acc_st);
    endfunction

    function automatic bit step_byte(logic [7:0] c);
        int unsigned lim;
        logic [8:0] t;
        lim = (lim_reg > 256) ? 256 : lim_reg;
        stream_pos++;
        buf_len++;
        if (buf_len >= lim) begin
            emit_error();
            return 1;
        end
        t = trans_m[cur_st * 256 + c];
        if (t[8]) begin
            if (acc_st >= 0) roll_back();
            else emit_error();
            return 1;
        end
        cur_st = t;
        enter_groups(t);
        if (!inf_acc[t]) return 0;
        if (inf_fin[t]) begin
            emit_match(t);
            return 1;
        end
        acc_st = t;
        acc_len = buf_len;
        return 0;
    endfunction

    function automatic bit finish_input();
        if (buf_len == 0) return 0;
        if (acc_st < 0) emit_error();
        else if (acc_len >= buf_len) emit_match(acc_st);
        else roll_back();
        return 1;
    endfunction

    function automatic void predict_words(lex_word_t w);
        int n0;
        bit done;
        t_rec r;
        n0 = lex_words_q.size();
        case (w.kind)
            K_DATA: begin
                done = step_byte(w.data_byte);
                if (!done && w.chunk_end && incr_reg == 0) done = finish_input();
                if (!done) push_word(ST_CONT, 0, lex_start, buf_len, 0, 0, 0, 0);
            end
            K_EOI: begin
                if (!finish_input()) push_word(ST_CONT, 0, lex_start, buf_len, 0, 0, 0, 0);
            end
            K_RESET: begin
                stream_pos = 0;
                restart_lexeme();
            end
            K_LD_TRAN: trans_m[w.state_index * 256 + w.data_byte] = w.next_state;
            K_LD_INFO: begin
                inf_acc[w.state_index]   = w.accept_flag;
                inf_fin[w.state_index]   = w.final_flag;
                inf_open[w.state_index]  = w.open_mask;
                inf_close[w.state_index] = w.close_mask;
                inf_first[w.state_index] = w.first_group;
                inf_cnt[w.state_index]   = w.accept_groups;
            end
            K_SET_OFS: begin
                lex_start = lex_start + (w.offset_value - stream_pos);
                stream_pos = w.offset_value;
            end
            default: ;
        endcase
        if (lex_words_q.size() > n0) begin
            r = lex_words_q.pop_back();
            r.last = 1'b1;
            lex_words_q.push_back(r);
        end
    endfunction

    // receiver: random stalls plus an optional long hold-off
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_cycles > 0) begin
                out_if.ready = 1'b0;
                hold_cycles--;
            end else begin
                out_if.ready = ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    function automatic void cmp_field(string f, longint unsigned e, longint unsigned a);
        if (e != a) begin
            $error("%s: expected %0h, got %0h", f, e, a);
            errors++;
        end
    endfunction

    // compare each result word with the oldest prediction
    always @(posedge clk) begin
        t_rec e;
        if (rst_n && out_if.valid && out_if.ready) begin
            if (lex_words_q.size() == 0) begin
                $error("unexpected result word, status %0d", out_if.status);
                errors++;
            end else begin
                e = lex_words_q.pop_front();
                cmp_field("status", e.status, out_if.status);
                cmp_field("accept_state", e.accept_state, out_if.accept_state);
                cmp_field("match_offset", e.match_offset, out_if.match_offset);
                cmp_field("match_length", e.match_length, out_if.match_length);
                cmp_field("group_index", e.group_index, out_if.group_index);
                cmp_field("group_present", e.group_present, out_if.group_present);
                cmp_field("group_offset", e.group_offset, out_if.group_offset);
                cmp_field("group_length", e.group_length, out_if.group_length);
                cmp_field("resume_offset", e.resume_offset, out_if.resume_offset);
                cmp_field("last", e.last, out_if.last);
            end
        end
    end

    task automatic send_word(lex_word_t w);
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid = 1'b0;
            @(negedge clk);
        end
        in_if.kind          = w.kind;
        in_if.data_byte     = w.data_byte;
        in_if.chunk_end     = w.chunk_end;
        in_if.state_index   = w.state_index;
        in_if.next_state    = w.next_state;
        in_if.accept_flag   = w.accept_flag;
        in_if.final_flag    = w.final_flag;
        in_if.open_mask     = w.open_mask;
        in_if.close_mask    = w.close_mask;
        in_if.first_group   = w.first_group;
        in_if.accept_groups = w.accept_groups;
        in_if.offset_value  = w.offset_value;
        in_if.valid         = 1'b1;
        do @(posedge clk); while (!in_if.ready);
        predict_words(w);
        @(negedge clk);
    endtask

    // hold the input idle until every predicted word is out, then let it settle
    task automatic wait_drained();
        in_if.valid = 1'b0;
        while (lex_words_q.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [8:0] val);
        wait_drained();
        cfg_if.index = idx;
        cfg_if.data  = val;
        cfg_if.valid = 1'b1;
        do @(posedge clk); while (!cfg_if.ready);
        case (idx)
            CFG_LIMIT: lim_reg = val;
            CFG_INCR:  incr_reg = val[0];
            CFG_GCNT:  gcnt_reg = val[4:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    function automatic logic [7:0] rand_sym();
        return syms[$urandom_range(N_SYM - 1)];
    endfunction

    function automatic lex_word_t blank_word(logic [2:0] k);
        lex_word_t w;
        w = '{default: '0};
        w.kind = k;
        return w;
    endfunction

    function automatic lex_word_t data_word(logic [7:0] c, logic ce);
        lex_word_t w;
        w = blank_word(K_DATA);
        w.data_byte = c;
        w.chunk_end = ce;
        return w;
    endfunction

    function automatic lex_word_t tran_word(logic [7:0] s, logic [7:0] c);
        lex_word_t w;
        w = blank_word(K_LD_TRAN);
        w.state_index = s;
        w.data_byte = c;
        // mostly live edges, some dead ones with varied negative encodings
        if ($urandom_range(99) < 78)
            w.next_state = {1'b0, used_states[$urandom_range(N_USED - 1)]};
        else if ($urandom_range(1))
            w.next_state = -9'sd1;
        else
            w.next_state = {1'b1, 8'($urandom)};
        return w;
    endfunction

    function automatic lex_word_t info_word(logic [7:0] s);
        lex_word_t w;
        w = blank_word(K_LD_INFO);
        w.state_index   = s;
        w.accept_flag   = ($urandom_range(99) < 50);
        w.final_flag    = ($urandom_range(99) < 25);
        w.open_mask     = 16'($urandom);
        w.close_mask    = 16'($urandom);
        w.first_group   = 4'($urandom_range(15));
        w.accept_groups = 5'($urandom_range(16));
        return w;
    endfunction

    function automatic lex_word_t random_word();
        int p;
        lex_word_t w;
        p = $urandom_range(99);
        if (p < 72) w = data_word(rand_sym(), ($urandom_range(99) < 12));
        else if (p < 80) w = blank_word(K_EOI);
        else if (p < 83) w = blank_word(K_RESET);
        else if (p < 89)
            w = tran_word(used_states[$urandom_range(N_USED - 1)], rand_sym());
        else if (p < 94) w = info_word(used_states[$urandom_range(N_USED - 1)]);
        else if (p < 97) begin
            w = blank_word(K_SET_OFS);
            w.offset_value = ($urandom_range(3) == 0) ? 32'hFFFF_FFF0 + $urandom_range(15)
                                                      : $urandom;
        end else begin
            w = blank_word($urandom_range(1) ? 3'd6 : 3'd7);
            w.data_byte = 8'($urandom);
        end
        return w;
    endfunction

    // info and every symbol column for each reachable state
    task automatic test_table_load();
        for (int i = 0; i < N_USED; i++) begin
            send_word(info_word(used_states[i]));
            for (int c = 0; c < N_SYM; c++) send_word(tran_word(used_states[i], syms[c]));
        end
    endtask

    task automatic test_directed();
        lex_word_t w;
        send_word(blank_word(K_EOI));                 // end of input with nothing buffered
        send_word(data_word(8'h00, 1'b0));
        send_word(data_word(8'hFF, 1'b0));
        send_word(data_word(8'h5A, 1'b1));            // chunk end forces end of input
        send_word(data_word(8'hA5, 1'b0));
        send_word(blank_word(K_EOI));
        w = blank_word(K_SET_OFS);
        w.offset_value = 32'hFFFF_FFFF;               // start moves with it, wraps
        send_word(w);
        for (int i = 0; i < 4; i++) send_word(data_word(rand_sym(), 1'b0));
        send_word(blank_word(K_RESET));
        send_word(blank_word(3'd6));
        send_word(blank_word(3'd7));
        // state 0 accepting, every group reported
        w = info_word(8'h00);
        w.accept_flag = 1'b1;
        w.final_flag = 1'b0;
        w.open_mask = 16'hFFFF;
        w.close_mask = 16'h0000;
        w.first_group = 4'd0;
        w.accept_groups = 5'd16;
        send_word(w);
        send_word(blank_word(K_RESET));
        for (int i = 0; i < 4; i++) send_word(data_word(rand_sym(), 1'b0));
        send_word(blank_word(K_EOI));
        w = info_word(8'hFF);
        w.accept_flag = 1'b1;
        w.final_flag = 1'b1;
        w.first_group = 4'd15;
        send_word(w);
        w = blank_word(K_SET_OFS);
        w.offset_value = 32'h0000_0000;
        send_word(w);
        send_word(data_word(8'hFF, 1'b1));
    endtask

    task automatic test_random(int n, int src_pct, int snk_pct);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        for (int i = 0; i < n; i++) send_word(random_word());
    endtask

    // long receiver stall while the sender keeps offering data
    task automatic test_backpressure();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_cycles = 300;
        for (int i = 0; i < 40; i++) send_word(data_word(rand_sym(), 1'b0));
    endtask

    // sender pauses until every result is out, then resumes
    task automatic test_drain_pause();
        for (int i = 0; i < 15; i++) send_word(random_word());
        wait_drained();
        for (int i = 0; i < 15; i++) send_word(random_word());
    endtask

    initial begin
        errors = 0;
        quiet_cycles = 0;
        hold_cycles = 0;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        lim_reg = 256;
        incr_reg = 0;
        gcnt_reg = 0;
        stream_pos = 0;
        for (int s = 0; s < 256; s++) begin
            inf_acc[s] = 0; inf_fin[s] = 0; inf_open[s] = 0;
            inf_close[s] = 0; inf_first[s] = 0; inf_cnt[s] = 0;
        end
        restart_lexeme();
        in_if.valid = 1'b0;
        in_if.kind = K_DATA;
        in_if.data_byte = '0;
        in_if.chunk_end = 1'b0;
        in_if.state_index = '0;
        in_if.next_state = '0;
        in_if.accept_flag = 1'b0;
        in_if.final_flag = 1'b0;
        in_if.open_mask = '0;
        in_if.close_mask = '0;
        in_if.first_group = '0;
        in_if.accept_groups = '0;
        in_if.offset_value = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = CFG_LIMIT;
        cfg_if.data = '0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_table_load();
        write_reg(CFG_LIMIT, 9'd511);
        write_reg(CFG_GCNT, 9'd16);
        test_directed();
        write_reg(CFG_LIMIT, 9'd256);
        test_random(80, 28, 51);
        write_reg(CFG_LIMIT, 9'd1);
        write_reg(CFG_INCR, 9'd1);
        write_reg(CFG_GCNT, 9'd0);
        test_random(20, 28, 51);
        write_reg(CFG_LIMIT, 9'd6);
        write_reg(CFG_GCNT, 9'd7);
        test_random(80, 51, 28);
        write_reg(CFG_LIMIT, 9'd256);
        write_reg(CFG_INCR, 9'd0);
        write_reg(CFG_GCNT, 9'd16);
        test_backpressure();
        test_random(80, 0, 0);
        test_drain_pause();

        wait_drained();
        repeat (30) @(posedge clk);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
